@@ rtl/ifr_pkg.sv @@
// ----------------------------------------------------------------------------
// ifr_pkg: shared types and constants of the integer factor resampler
// Mode and register codes, the command kinds passed from the front end to
// the back end, and the front end's state encoding.
// ----------------------------------------------------------------------------
package ifr_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 24;
	localparam int unsigned MAX_FACTOR_DEF  = 64;

	localparam int unsigned MODE_BITS     = 2;
	localparam int unsigned FACTOR_BITS   = 7;
	localparam int unsigned CFG_IDX_BITS  = 1;
	localparam int unsigned CFG_DATA_BITS = 7;
	localparam int unsigned KIND_BITS     = 2;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_DECIMATE = 2'd0,
		MODE_ZERO     = 2'd1,
		MODE_HOLD     = 2'd2,
		MODE_LINEAR   = 2'd3
	} mode_t;

	localparam mode_t                  MODE_RESET   = MODE_HOLD;
	localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 7'd1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODE   = 1'b0,
		REG_FACTOR = 1'b1
	} cfg_reg_t;

	typedef enum logic [KIND_BITS-1:0] {
		CMD_ZERO = 2'd0,
		CMD_HOLD = 2'd1,
		CMD_LIN  = 2'd2
	} cmd_kind_t;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

endpackage

@@ rtl/ifr_fifo.sv @@
// ----------------------------------------------------------------------------
// ifr_fifo: two-entry register queue
// Decouples a producer from a consumer; write and read may happen together.
// ----------------------------------------------------------------------------
module ifr_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	output logic             wr_full,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic             rd_empty,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_full  = (cnt_q == 2'd2);
	assign rd_empty = (cnt_q == 2'd0);
	assign do_wr    = wr_en & ~wr_full;
	assign do_rd    = rd_en & ~rd_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/ifr_front.sv @@
// ----------------------------------------------------------------------------
// ifr_front: input side of the resampler
// Takes samples, keeps the previous one and the decimation phase, and turns
// each into a command, in decimate mode only at phase zero. Above factor one,
// linear mode divides the difference by the factor, a quotient bit per cycle.
// ----------------------------------------------------------------------------
module ifr_front import ifr_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int unsigned MAX_FACTOR  = MAX_FACTOR_DEF,
	localparam int unsigned FW    = $clog2(MAX_FACTOR + 1),
	localparam int unsigned CMD_W = KIND_BITS + 1 + 2 * FW + 2 * SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  mode_t                         mode,
	input  logic        [FW-1:0]          f_eff,
	input  logic                          cmd_full,
	output logic                          cmd_push,
	output logic        [CMD_W-1:0]       cmd_data
);

	localparam int unsigned SB   = SAMPLE_BITS;
	localparam int unsigned PW   = $clog2(MAX_FACTOR);
	localparam int unsigned CNTW = $clog2(SAMPLE_BITS + 1);

	front_state_t     state_q;
	logic [SB-1:0]    prev_q;
	logic [PW-1:0]    phase_q;
	logic [SB-1:0]    div_quo_q;
	logic [FW-1:0]    div_rem_q;
	logic [CNTW-1:0]  div_cnt_q;
	logic [SB-1:0]    base_q;
	logic             neg_q;

	logic             accept;
	logic [SB:0]      diff;
	logic [SB:0]      diff_abs;
	logic             diff_neg;
	logic [FW-1:0]    phase_inc;
	logic             phase_wrap;
	logic [FW:0]      trial;
	logic [FW:0]      trial_sub;
	logic             trial_ge;
	logic [FW-1:0]    rem_next;
	logic             f_one;

	cmd_kind_t        cmd_kind;
	logic             cmd_neg;
	logic [FW-1:0]    cmd_f;
	logic [FW-1:0]    cmd_rem;
	logic [SB-1:0]    cmd_quo;
	logic [SB-1:0]    cmd_smp;

	assign full     = (state_q != F_IDLE) | cmd_full;
	assign accept   = push & ~full;
	assign diff     = {in_sample[SB-1], in_sample} - {prev_q[SB-1], prev_q};
	assign diff_neg = diff[SB];
	assign diff_abs = diff_neg ? (~diff + 1'b1) : diff;
	assign f_one    = (f_eff == FW'(1));

	assign phase_inc  = FW'(phase_q) + FW'(1);
	assign phase_wrap = (phase_inc >= f_eff);

	// one restoring division step
	assign trial     = {div_rem_q, div_quo_q[SB-1]};
	assign trial_ge  = (trial >= {1'b0, f_eff});
	assign trial_sub = trial - {1'b0, f_eff};
	assign rem_next  = trial_ge ? trial_sub[FW-1:0] : trial[FW-1:0];

	always_comb begin
		cmd_push = 1'b0;
		cmd_kind = CMD_HOLD;
		cmd_neg  = 1'b0;
		cmd_f    = f_eff;
		cmd_rem  = '0;
		cmd_quo  = '0;
		cmd_smp  = in_sample;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					unique case (mode)
						MODE_DECIMATE: begin
							cmd_push = (phase_q == '0);
							cmd_f    = FW'(1);
						end
						MODE_ZERO: begin
							cmd_push = 1'b1;
							cmd_kind = CMD_ZERO;
						end
						MODE_HOLD: begin
							cmd_push = 1'b1;
						end
						MODE_LINEAR: begin
							cmd_push = f_one;
						end
						default: begin
							cmd_push = 1'b0;
						end
					endcase
				end
			end
			F_DIV: begin
				cmd_push = 1'b0;
			end
			F_PUSH: begin
				cmd_push = ~cmd_full;
				cmd_kind = CMD_LIN;
				cmd_neg  = neg_q;
				cmd_rem  = div_rem_q;
				cmd_quo  = div_quo_q;
				cmd_smp  = base_q;
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	assign cmd_data = {cmd_kind, cmd_neg, cmd_f, cmd_rem, cmd_quo, cmd_smp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			prev_q    <= '0;
			phase_q   <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						prev_q <= in_sample;
						if (mode == MODE_DECIMATE) begin
							phase_q <= phase_wrap ? '0 : phase_inc[PW-1:0];
						end
						if (mode == MODE_LINEAR && !f_one) begin
							div_cnt_q <= CNTW'(SB);
							state_q   <= F_DIV;
						end
					end
				end
				F_DIV: begin
					div_cnt_q <= div_cnt_q - CNTW'(1);
					if (div_cnt_q == CNTW'(1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!cmd_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			div_quo_q <= diff_abs[SB-1:0];
			div_rem_q <= '0;
			base_q    <= prev_q;
			neg_q     <= diff_neg;
		end else if (state_q == F_DIV) begin
			div_quo_q <= {div_quo_q[SB-2:0], trial_ge};
			div_rem_q <= rem_next;
		end
	end

	a_div_to_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV && div_cnt_q == CNTW'(1)) |=> (state_q == F_PUSH))
		else $error("divider did not hand over to the push state");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into a full queue");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV) |-> (div_rem_q < f_eff))
		else $error("partial remainder reached the divisor");

endmodule

@@ rtl/ifr_back.sv @@
// ----------------------------------------------------------------------------
// ifr_back: output side of the resampler
// Carries out one command at a time, one result per cycle while out_full is
// low: zero-pad, hold, or linear steps from a running quotient and remainder.
// ----------------------------------------------------------------------------
module ifr_back import ifr_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int unsigned MAX_FACTOR  = MAX_FACTOR_DEF,
	localparam int unsigned FW    = $clog2(MAX_FACTOR + 1),
	localparam int unsigned CMD_W = KIND_BITS + 1 + 2 * FW + 2 * SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_empty,
	output logic                   cmd_pop,
	input  logic [CMD_W-1:0]       cmd_data,
	input  logic                   out_full,
	output logic                   out_push,
	output logic [SAMPLE_BITS:0]   out_data
);

	localparam int unsigned SB      = SAMPLE_BITS;
	localparam int unsigned QUO_LSB = SB;
	localparam int unsigned REM_LSB = 2 * SB;
	localparam int unsigned F_LSB   = 2 * SB + FW;
	localparam int unsigned NEG_BIT = 2 * SB + 2 * FW;
	localparam int unsigned KND_LSB = NEG_BIT + 1;

	logic             active_q;
	cmd_kind_t        kind_q;
	logic [SB-1:0]    smp_q;
	logic             neg_q;
	logic [FW-1:0]    f_q;
	logic [SB-1:0]    quo_q;
	logic [FW-1:0]    remd_q;
	logic [FW-1:0]    cnt_q;
	logic             first_q;
	logic [SB-1:0]    qacc_q;
	logic [FW-1:0]    racc_q;

	logic             emit;
	logic             last;
	logic [FW:0]      rsum;
	logic [FW:0]      rsum_sub;
	logic             carry;
	logic [FW-1:0]    r_n;
	logic [SB-1:0]    q_n;
	logic [SB:0]      lin_mag;
	logic [SB:0]      lin_val;
	logic [SB-1:0]    value;

	assign emit    = active_q & ~out_full;
	assign last    = (cnt_q == FW'(1));
	assign cmd_pop = ~cmd_empty & (~active_q | (emit & last));

	// advance quotient and remainder of diff * j / f by one step of j
	assign rsum     = {1'b0, racc_q} + {1'b0, remd_q};
	assign carry    = (rsum >= {1'b0, f_q});
	assign rsum_sub = rsum - {1'b0, f_q};
	assign r_n      = carry ? rsum_sub[FW-1:0] : rsum[FW-1:0];
	assign q_n      = qacc_q + quo_q + SB'(carry);

	assign lin_mag = {1'b0, q_n};
	assign lin_val = {smp_q[SB-1], smp_q} + (neg_q ? (~lin_mag + 1'b1) : lin_mag);

	always_comb begin
		case (kind_q)
			CMD_ZERO: value = first_q ? smp_q : '0;
			CMD_HOLD: value = smp_q;
			CMD_LIN:  value = lin_val[SB-1:0];
			default:  value = smp_q;
		endcase
	end

	assign out_push = emit;
	assign out_data = {last, value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (cmd_pop) begin
			active_q <= 1'b1;
		end else if (emit && last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			kind_q  <= cmd_kind_t'(cmd_data[KND_LSB +: KIND_BITS]);
			neg_q   <= cmd_data[NEG_BIT];
			f_q     <= cmd_data[F_LSB +: FW];
			remd_q  <= cmd_data[REM_LSB +: FW];
			quo_q   <= cmd_data[QUO_LSB +: SB];
			smp_q   <= cmd_data[SB-1:0];
			cnt_q   <= cmd_data[F_LSB +: FW];
			first_q <= 1'b1;
			qacc_q  <= '0;
			racc_q  <= '0;
		end else if (emit) begin
			cnt_q   <= cnt_q - FW'(1);
			first_q <= 1'b0;
			qacc_q  <= q_n;
			racc_q  <= r_n;
		end
	end

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q != '0))
		else $error("active command with no results left");

	a_racc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (racc_q < f_q))
		else $error("running remainder reached the factor");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (active_q && first_q))
		else $error("popped command not started");

endmodule

@@ rtl/integer_factor_resampler_core.sv @@
// ----------------------------------------------------------------------------
// integer_factor_resampler_core: integer factor decimator / interpolator
// Decimate, zero-pad, hold or linear upsample by a programmable factor.
//
//  channel   direction  handshake                  payload
//  input     in         push / full                in_sample
//  result    out        pop / empty                out_sample, run_last
//  config    in         cfg_we (no wait)           cfg_idx, cfg_wdata
//
// The front end takes one sample per cycle while the command queue has room
// in decimate, zero-pad and hold modes, and in linear mode at factor one; in
// linear mode above factor one it takes a sample, runs its bit-serial divider
// and then pushes the command before it takes the next sample.
// The back end gives one result per cycle while the result queue has room,
// factor results per upsampled sample. A two-entry command queue lets both
// run at once.
// Reset clears all control state at once; there is no clearing pass.
// A stalled result queue stalls the back end, then the front end via full.
// ----------------------------------------------------------------------------
module integer_factor_resampler_core import ifr_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int unsigned MAX_FACTOR  = MAX_FACTOR_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          run_last,
	input  logic                          cfg_we,
	input  logic        [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic        [CFG_DATA_BITS-1:0] cfg_wdata
);

	localparam int unsigned FW    = $clog2(MAX_FACTOR + 1);
	localparam int unsigned CW    = (FW > FACTOR_BITS) ? FW : FACTOR_BITS;
	localparam int unsigned CMD_W = KIND_BITS + 1 + 2 * FW + 2 * SAMPLE_BITS;

	mode_t                    mode_q;
	logic [FACTOR_BITS-1:0]   factor_q;
	logic [CW-1:0]            fac_ext;
	logic [FW-1:0]            f_eff;

	logic                     cmd_push;
	logic                     cmd_full;
	logic [CMD_W-1:0]         cmd_wdata;
	logic                     cmd_pop;
	logic                     cmd_empty;
	logic [CMD_W-1:0]         cmd_rdata;

	logic                     res_push;
	logic                     res_full;
	logic [SAMPLE_BITS:0]     res_wdata;
	logic [SAMPLE_BITS:0]     res_rdata;

	// Configuration registers: to be written only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RESET;
			factor_q <= FACTOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_MODE:   mode_q   <= mode_t'(cfg_wdata[MODE_BITS-1:0]);
				REG_FACTOR: factor_q <= cfg_wdata[FACTOR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the factor to 1..MAX_FACTOR; zero behaves as one.
	assign fac_ext = CW'(factor_q);
	always_comb begin
		if (fac_ext == '0) begin
			f_eff = FW'(1);
		end else if (fac_ext > CW'(MAX_FACTOR)) begin
			f_eff = FW'(MAX_FACTOR);
		end else begin
			f_eff = FW'(fac_ext);
		end
	end

	// Front end: accept each transaction, track phase and previous sample.
	ifr_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_FACTOR  (MAX_FACTOR)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_sample (in_sample),
		.mode      (mode_q),
		.f_eff     (f_eff),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd_data  (cmd_wdata)
	);

	// Hold pending commands so the front end can run ahead of the back end.
	ifr_fifo #(
		.WIDTH (CMD_W)
	) u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_full  (cmd_full),
		.wr_data  (cmd_wdata),
		.rd_en    (cmd_pop),
		.rd_empty (cmd_empty),
		.rd_data  (cmd_rdata)
	);

	// Back end: expand each command into its results.
	ifr_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_FACTOR  (MAX_FACTOR)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd_data  (cmd_rdata),
		.out_full  (res_full),
		.out_push  (res_push),
		.out_data  (res_wdata)
	);

	// Result queue: registers the outputs and decouples the consumer.
	ifr_fifo #(
		.WIDTH (SAMPLE_BITS + 1)
	) u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_push),
		.wr_full  (res_full),
		.wr_data  (res_wdata),
		.rd_en    (pop),
		.rd_empty (empty),
		.rd_data  (res_rdata)
	);

	assign out_sample = res_rdata[SAMPLE_BITS-1:0];
	assign run_last   = res_rdata[SAMPLE_BITS];

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for integer_factor_resampler_core
// Drives samples through the push/full queue and the configuration port. It
// predicts every resampled output in every mode and factor, and compares the
// popped outputs field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module testbench;
	import ifr_pkg::*;

	localparam int unsigned SW    = SAMPLE_BITS_DEF;
	localparam int unsigned FMAX  = MAX_FACTOR_DEF;
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	// Cycles to wait once nothing is due: covers a dropped decimate sample
	// still in the front end, or a linear divide in flight.
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned PHASES        = 10;
	localparam int unsigned PHASE_ITEMS   = 23;

	typedef struct packed {
		logic signed [SW-1:0] sample;
		logic                 last;
	} resampled_t;

	// Mirror of the resampler state; holds the outputs still due from the DUT.
	class resample_ledger;
		mode_t                mode;
		logic [FACTOR_BITS-1:0] factor;
		logic signed [SW-1:0] prev;
		logic [5:0]           phase;
		resampled_t           due[$];
		int unsigned          errors;

		function new();
			mode   = MODE_RESET;
			factor = FACTOR_RESET;
			prev   = '0;
			phase  = '0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx == REG_MODE) begin
				mode = mode_t'(data[MODE_BITS-1:0]);
			end else begin
				factor = data[FACTOR_BITS-1:0];
			end
		endfunction

		function void take_sample(logic signed [SW-1:0] cur);
			longint signed ratio;
			longint signed base;
			longint signed diff;
			longint signed v;
			resampled_t    r;
			if (factor == 0) begin
				ratio = 1;
			end else if (factor > FMAX) begin
				ratio = FMAX;
			end else begin
				ratio = longint'(factor);
			end
			base = longint'(prev);
			diff = longint'(cur) - base;
			prev = cur;
			if (mode == MODE_DECIMATE) begin
				if (phase == 0) begin
					r.sample = cur;
					r.last   = 1'b1;
					due.push_back(r);
				end
				if (longint'(phase) + 1 >= ratio) begin
					phase = '0;
				end else begin
					phase = phase + 6'd1;
				end
			end else begin
				for (longint signed j = 1; j <= ratio; j++) begin
					case (mode)
						MODE_ZERO: v = (j == 1) ? longint'(cur) : 0;
						MODE_HOLD: v = longint'(cur);
						default:   v = base + (diff * j) / ratio;
					endcase
					r.sample = v[SW-1:0];
					r.last   = (j == ratio);
					due.push_back(r);
				end
			end
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction

		function void match_output(logic signed [SW-1:0] sample, logic last);
			resampled_t r;
			if (due.size() == 0) begin
				$error("unexpected output: out_sample %0d run_last %0b", sample, last);
				errors++;
				return;
			end
			r = due.pop_front();
			if (sample !== r.sample) begin
				$error("out_sample: expected %0d, actual %0d", r.sample, sample);
				errors++;
			end
			if (last !== r.last) begin
				$error("run_last: expected %0b, actual %0b", r.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic signed [SW-1:0]     in_sample;
	logic                     empty;
	logic                     pop;
	logic signed [SW-1:0]     out_sample;
	logic                     run_last;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	resample_ledger ledger = new();
	logic           calm = 1'b1;	// no idling on either side while set
	int unsigned    pop_gap = 0;

	integer_factor_resampler_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_sample (in_sample),
		.empty     (empty),
		.pop       (pop),
		.out_sample(out_sample),
		.run_last  (run_last),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: pop at the falling edge, stalling in short random bursts.
	always @(negedge clk) begin
		if (!calm && pop_gap == 0 && $urandom_range(0, 5) == 0) begin
			pop_gap = $urandom_range(1, 6);
		end
		if (pop_gap != 0) begin
			pop <= 1'b0;
			pop_gap = pop_gap - 1;
		end else begin
			pop <= 1'b1;
		end
	end

	// Check each result transaction at the rising edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			ledger.match_output(out_sample, run_last);
		end
	end

	// Offer one sample and hold it until the transaction completes.
	task automatic send_sample(logic signed [SW-1:0] s);
		@(negedge clk);
		push      <= 1'b1;
		in_sample <= s;
		@(posedge clk);
		while (full) @(posedge clk);
		ledger.take_sample(s);
	endtask

	// Drop push for a random burst, with junk on the data lines.
	task automatic sender_gap();
		if (!calm && $urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				push      <= 1'b0;
				in_sample <= SW'($urandom);
			end
		end
	endtask

	// Hold off the sender until every predicted output has been popped.
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		ledger.write_reg(idx, data);
	endtask

	// Let the block go idle, then program both registers. Junk the spare
	// upper bits of the mode word; the block must ignore them.
	task automatic reconfigure(mode_t m, logic [FACTOR_BITS-1:0] f);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_MODE, {5'($urandom_range(0, 31)), m});
			write_reg(REG_FACTOR, f);
		end else begin
			write_reg(REG_FACTOR, f);
			write_reg(REG_MODE, {5'($urandom_range(0, 31)), m});
		end
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
			3, 4:    return SW'($urandom_range(0, 400)) - SW'(200);
			default: return SW'($urandom);
		endcase
	endfunction

	// Mostly small ratios to keep the run short; now and then zero, the
	// maximum and values above it that must saturate.
	function automatic logic [FACTOR_BITS-1:0] pick_factor();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return FACTOR_BITS'(FMAX);
			2:       return FACTOR_BITS'($urandom_range(FMAX + 1, 127));
			3, 4, 5: return FACTOR_BITS'($urandom_range(1, 4));
			default: return FACTOR_BITS'($urandom_range(2, 12));
		endcase
	endfunction

	initial begin
		#5_000_000;
		$display("integer_factor_resampler_core verification failed");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		in_sample = '0;
		pop       = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = REG_MODE;
		cfg_wdata = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: hold mode at factor one passes samples straight through.
		send_sample('0);
		send_sample(S_MAX);
		send_sample(S_MIN);

		// Linear at the largest ratio across the full swing, then a flat step.
		reconfigure(MODE_LINEAR, FACTOR_BITS'(FMAX));
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(S_MIN);
		send_sample(S_MAX);

		// Zero factor behaves as one.
		reconfigure(MODE_LINEAR, '0);
		send_sample(SW'(100));
		send_sample(-SW'(100));

		// Oversized factor saturates.
		reconfigure(MODE_ZERO, 7'd127);
		send_sample('1);

		// Decimate by three, then by five, then by two with the phase well past it.
		reconfigure(MODE_DECIMATE, 7'd3);
		repeat (7) send_sample(pick_sample());
		reconfigure(MODE_DECIMATE, 7'd5);
		repeat (3) send_sample(pick_sample());
		reconfigure(MODE_DECIMATE, 7'd2);
		repeat (3) send_sample(pick_sample());

		// Phase is held outside decimate; linear starts from the latest sample.
		reconfigure(MODE_HOLD, 7'd2);
		send_sample(S_MIN);
		reconfigure(MODE_LINEAR, 7'd4);
		send_sample(S_MAX);
		reconfigure(MODE_DECIMATE, 7'd3);
		send_sample(pick_sample());

		// Random phases; the last two run with no idling at all.
		for (int p = 0; p < PHASES; p++) begin
			reconfigure(mode_t'($urandom_range(0, 3)), pick_factor());
			calm = (p >= PHASES - 2) || ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 3 && k == 10) begin
					wait_drained();
				end
				sender_gap();
				send_sample(pick_sample());
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0) begin
			$display("integer_factor_resampler_core verification clean");
		end else begin
			$display("integer_factor_resampler_core verification failed");
		end
		$finish;
	end

endmodule
